FILE: rtl/core/mfc_pkg.sv
package mfc_pkg;

    typedef struct packed {
        logic [63:0] raw_value;
        logic        is_last;
    } in_item_t;

    typedef struct packed {
        logic [31:0] float_bits;
        logic        is_last_res;
    } out_item_t;

    localparam logic [2:0] FMT_SINGLE = 3'd0;
    localparam logic [2:0] FMT_HALF   = 3'd1;
    localparam logic [2:0] FMT_U8     = 3'd2;
    localparam logic [2:0] FMT_S8     = 3'd3;
    localparam logic [2:0] FMT_S32    = 3'd4;
    localparam logic [2:0] FMT_S64    = 3'd5;

endpackage

FILE: rtl/core/multi_format_to_fp32_converter.sv
// An accepted start passes the stage 1 and stage 2 registers before the result strobe.
// Throughput: one item per cycle; busy is held low, so start may stay high.
// Stage 1 registers the item and forms sign, magnitude and leading-one position.
// Stage 2 normalizes, rounds to nearest even and packs integers; FP inputs pass through.
// Reset (rst_n low, asynchronous) clears the stage valids and sets the format to single.
module multi_format_to_fp32_converter (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  mfc_pkg::in_item_t    in_item,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [2:0]           cfg_data,
    output logic                 result_valid,
    output mfc_pkg::out_item_t   result
);
    import mfc_pkg::*;

    logic [2:0]  fmt_reg;
    logic        s1_valid_reg;
    logic        s1_neg_reg;
    logic [63:0] s1_mag_reg;
    logic [5:0]  s1_pos_reg;
    logic        s1_pass_reg;
    logic [31:0] s1_pass_bits_reg;
    logic        s1_last_reg;
    logic        s2_valid_reg;
    out_item_t   s2_item_reg;

    logic        neg_next;
    logic [63:0] mag_next;
    logic [5:0]  pos_next;
    logic        pass_next;
    logic [31:0] pass_bits_next;
    logic [63:0] raw;
    logic [4:0]  h_exp;
    logic [9:0]  h_man;
    logic [3:0]  h_lz;
    logic [9:0]  h_norm;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign raw       = in_item.raw_value;
    assign h_exp     = raw[14:10];
    assign h_man     = raw[9:0];

    always_comb
    begin
        h_lz = 4'd0;
        for (int i = 0; i < 10; i++)
        begin
            if (h_man[i])
            begin
                h_lz = 4'(9 - i);
            end
        end
        h_norm = 10'(h_man << (h_lz + 4'd1));
    end

    always_comb
    begin
        neg_next       = 1'b0;
        mag_next       = '0;
        pass_next      = 1'b0;
        pass_bits_next = raw[31:0];
        case (fmt_reg)
            FMT_HALF:
            begin
                pass_next = 1'b1;
                if (h_exp == 5'd0)
                begin
                    if (h_man == 10'd0)
                    begin
                        pass_bits_next = {raw[15], 31'd0};
                    end
                    else
                    begin
                        pass_bits_next = {raw[15], 8'(8'd112 - {4'd0, h_lz}),
                                          h_norm, 13'd0};
                    end
                end
                else if (h_exp == 5'd31)
                begin
                    pass_bits_next = {raw[15], 8'hFF, h_man, 13'd0};
                end
                else
                begin
                    pass_bits_next = {raw[15], 8'({3'd0, h_exp} + 8'd112), h_man, 13'd0};
                end
            end
            FMT_U8:
            begin
                mag_next = {56'd0, raw[7:0]};
            end
            FMT_S8:
            begin
                neg_next = raw[7];
                mag_next = {56'd0, raw[7] ? 8'(8'd0 - raw[7:0]) : raw[7:0]};
                if (raw[7:0] == 8'h80)
                begin
                    mag_next = 64'd128;
                end
            end
            FMT_S32:
            begin
                neg_next = raw[31];
                mag_next = raw[31] ? 64'(33'h1_0000_0000 - {1'b0, raw[31:0]})
                                   : {32'd0, raw[31:0]};
            end
            FMT_S64:
            begin
                neg_next = raw[63];
                mag_next = raw[63] ? 64'(64'd0 - raw) : raw;
            end
            default:
            begin
                pass_next = 1'b1;
            end
        endcase
        pos_next = 6'd0;
        for (int i = 0; i < 64; i++)
        begin
            if (mag_next[i])
            begin
                pos_next = 6'(i);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg      <= FMT_SINGLE;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                fmt_reg <= cfg_data;
            end
            s1_valid_reg <= start && !busy;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            s1_neg_reg       <= neg_next;
            s1_mag_reg       <= mag_next;
            s1_pos_reg       <= pos_next;
            s1_pass_reg      <= pass_next;
            s1_pass_bits_reg <= pass_bits_next;
            s1_last_reg      <= in_item.is_last;
        end
    end

    logic [63:0] norm;
    logic [23:0] mant;
    logic        guard;
    logic        sticky;
    logic        rnd_up;
    logic [24:0] mant_r;
    logic [7:0]  exp_r;
    logic [31:0] int_bits;

    always_comb
    begin
        norm   = s1_mag_reg << (6'd63 - s1_pos_reg);
        mant   = norm[63:40];
        guard  = norm[39];
        sticky = |norm[38:0];
        rnd_up = guard && (sticky || mant[0]);
        mant_r = {1'b0, mant} + {24'd0, rnd_up};
        exp_r  = 8'({2'd0, s1_pos_reg} + 8'd127 + {7'd0, mant_r[24]});
        if (s1_mag_reg == 64'd0)
        begin
            int_bits = 32'd0;
        end
        else
        begin
            int_bits = {s1_neg_reg, exp_r,
                        mant_r[24] ? mant_r[23:1] : mant_r[22:0]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            s2_item_reg.float_bits  <= s1_pass_reg ? s1_pass_bits_reg : int_bits;
            s2_item_reg.is_last_res <= s1_last_reg;
        end
    end

    assign result_valid = s2_valid_reg;
    assign result       = s2_item_reg;

endmodule

FILE: rtl/core/mfc_checker.sv
module mfc_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input mfc_pkg::in_item_t   in_item,
    input logic                result_valid,
    input mfc_pkg::out_item_t  result
);
    import mfc_pkg::*;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##2 result_valid)
        else $error("item without result");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(start && !busy, 2))
        else $error("result without item");

    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##2 (result.is_last_res == $past(in_item.is_last, 2)))
        else $error("last flag mismatch");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy asserted");

endmodule

bind multi_format_to_fp32_converter mfc_checker u_mfc_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .result_valid(result_valid), .result(result)
);
